[sv/light_level_smoother_classifier_assert.svh]
// Assertion macros for the light level smoother and classifier checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef LIGHT_LEVEL_SMOOTHER_CLASSIFIER_ASSERT_SVH
`define LIGHT_LEVEL_SMOOTHER_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lls_pkg.sv]
// Shared types and constants for the light level smoother and classifier.
// No dependencies.
`default_nettype none

package lls_pkg;

    localparam int LEVEL_W     = 10;
    localparam int PCT_W       = 7;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 4;

    typedef logic [LEVEL_W-1:0]   level_t;
    typedef logic [PCT_W-1:0]     pct_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_PLAIN      = 2'd0;
    localparam mode_t MODE_CAL_DARK   = 2'd1;
    localparam mode_t MODE_CAL_BRIGHT = 2'd2;

    localparam status_t STATUS_NORMAL = 2'd0;
    localparam status_t STATUS_DARK   = 2'd1;
    localparam status_t STATUS_BRIGHT = 2'd2;

    localparam cfg_idx_t REG_DARK_THRESHOLD   = 4'd0;
    localparam cfg_idx_t REG_BRIGHT_THRESHOLD = 4'd1;

    localparam level_t LEVEL_MAX    = 10'd1023;
    localparam level_t CAL_MARGIN   = 10'd50;
    localparam level_t DARK_RESET   = 10'd300;
    localparam level_t BRIGHT_RESET = 10'd700;

    // level*100/1023 == (level*PCT_RECIP) >> PCT_SHIFT for every 10-bit level
    localparam int          PCT_RECIP_W = 17;
    localparam int          PCT_SHIFT   = 20;
    localparam int          PCT_PROD_W  = LEVEL_W + PCT_RECIP_W;
    localparam logic [16:0] PCT_RECIP   = 17'd102501;

    typedef struct packed {
        mode_t  mode;
        level_t sample;
    } in_item_t;

    typedef struct packed {
        level_t  smoothed_level;
        pct_t    brightness_percent;
        status_t light_status;
        level_t  active_dark_level;
        level_t  active_bright_level;
    } out_item_t;

    typedef struct packed {
        cfg_idx_t index;
        level_t   data;
    } cfg_item_t;

    // Stage occupancy and operation passed down the pipeline
    typedef struct packed {
        logic  valid;
        mode_t mode;
    } stage_ctl_t;

    // Decoded threshold writes
    typedef struct packed {
        logic   dark_we;
        logic   bright_we;
        level_t data;
    } thr_wr_t;

endpackage

`default_nettype wire

[sv/lls_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
// Used for sample, result and configuration transfers; no dependencies.
`default_nettype none

interface lls_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/lls_window.sv]
// Sample window: ring of the last WINDOW_LEN samples and the running total.
// Depends on lls_pkg.
`default_nettype none

module lls_window
    import lls_pkg::*;
#(
    parameter int WINDOW_LEN = 8,
    parameter int PTR_W      = 3,
    parameter int TOTAL_W    = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire in_item_t           item,
    input  wire logic               ready_dn,
    output logic                    ready_up,
    output stage_ctl_t              ctl,
    output logic [TOTAL_W-1:0]      total
);

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_LEN - 1);

    level_t                 ring_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]  fill_reg;
    logic [PTR_W-1:0]       pos_reg;
    logic [PTR_W-1:0]       pos_next;
    level_t                 oldest_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic                   valid_reg;
    mode_t                  mode_reg;

    assign ready_up   = !valid_reg || ready_dn;
    assign pos_next   = (pos_reg == LAST_POS) ? '0 : pos_reg + PTR_W'(1);
    assign total_next = total_reg - TOTAL_W'(oldest_reg) + TOTAL_W'(item.sample);

    // Write the new sample over the oldest entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[pos_reg] <= item.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            pos_reg    <= '0;
            oldest_reg <= '0;
            total_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg[pos_reg] <= 1'b1;
                pos_reg           <= pos_next;
                total_reg         <= total_next;
                // Prefetch the entry the next sample replaces; a one-entry
                // window replaces what it just wrote.
                if (pos_next == pos_reg)
                begin
                    oldest_reg <= item.sample;
                end
                else
                begin
                    oldest_reg <= fill_reg[pos_next] ? ring_mem[pos_next] : '0;
                end
            end
            if (ready_up)
            begin
                valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= item.mode;
        end
    end

    // Total holds while the stage is stalled, since nothing is accepted then
    assign ctl.valid = valid_reg;
    assign ctl.mode  = mode_reg;
    assign total     = total_reg;

endmodule

`default_nettype wire

[sv/lls_level_scale.sv]
// Average stage: running total divided by the window length.
// Depends on lls_pkg.
`default_nettype none

module lls_level_scale
    import lls_pkg::*;
#(
    parameter int WINDOW_LEN = 8,
    parameter int TOTAL_W    = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stage_ctl_t         ctl_in,
    input  wire logic [TOTAL_W-1:0] total,
    input  wire logic               ready_dn,
    output logic                    ready_up,
    output stage_ctl_t              ctl_out,
    output level_t                  level
);

    // Rounded-up reciprocal; exact for every total below 2**TOTAL_W
    localparam int              LOG_N   = $clog2(WINDOW_LEN);
    localparam int              SHIFT   = TOTAL_W + LOG_N;
    localparam int              RECIP_W = SHIFT + 1;
    localparam int              PROD_W  = TOTAL_W + RECIP_W;
    localparam longint unsigned RECIP   =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

    logic [PROD_W-1:0] prod;
    logic              valid_reg;
    mode_t             mode_reg;
    level_t            level_reg;

    assign ready_up = !valid_reg || ready_dn;
    assign prod     = PROD_W'(total) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_in.valid)
        begin
            mode_reg  <= ctl_in.mode;
            level_reg <= prod[SHIFT +: LEVEL_W];
        end
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.mode  = mode_reg;
    assign level         = level_reg;

endmodule

`default_nettype wire

[sv/lls_classify.sv]
// Result stage: threshold calibration, percent scaling, status and result register.
// Depends on lls_pkg.
`default_nettype none

module lls_classify
    import lls_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl_in,
    input  wire level_t     level,
    input  wire thr_wr_t    thr_wr,
    input  wire logic       out_ready,
    output logic            ready_up,
    output logic            out_valid,
    output out_item_t       out_item
);

    level_t                  dark_reg;
    level_t                  bright_reg;
    level_t                  dark_next;
    level_t                  bright_next;
    logic [LEVEL_W:0]        dark_sum;
    level_t                  dark_cal;
    level_t                  bright_cal;
    logic [PCT_PROD_W-1:0]   pct_prod;
    status_t                 status;
    logic                    advance;
    logic                    valid_reg;
    out_item_t               item_reg;

    assign ready_up = !valid_reg || out_ready;
    assign advance  = ctl_in.valid && ready_up;

    assign dark_sum   = {1'b0, level} + {1'b0, CAL_MARGIN};
    assign dark_cal   = (dark_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : dark_sum[LEVEL_W-1:0];
    assign bright_cal = (level < CAL_MARGIN) ? '0 : level - CAL_MARGIN;
    assign pct_prod   = PCT_PROD_W'(level) * PCT_PROD_W'(PCT_RECIP);

    always_comb
    begin
        dark_next   = dark_reg;
        bright_next = bright_reg;
        case (ctl_in.mode)
            MODE_CAL_DARK:   dark_next   = dark_cal;
            MODE_CAL_BRIGHT: bright_next = bright_cal;
            default:         ;
        endcase
    end

    // Judge against the thresholds in force after this item
    always_comb
    begin
        if (level < dark_next)
        begin
            status = STATUS_DARK;
        end
        else if (level > bright_next)
        begin
            status = STATUS_BRIGHT;
        end
        else
        begin
            status = STATUS_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg   <= DARK_RESET;
            bright_reg <= BRIGHT_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (ready_up)
            begin
                valid_reg <= ctl_in.valid;
            end
            // A register write wins over calibration
            if (thr_wr.dark_we)
            begin
                dark_reg <= thr_wr.data;
            end
            else if (advance)
            begin
                dark_reg <= dark_next;
            end
            if (thr_wr.bright_we)
            begin
                bright_reg <= thr_wr.data;
            end
            else if (advance)
            begin
                bright_reg <= bright_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg.smoothed_level      <= level;
            item_reg.brightness_percent  <= pct_prod[PCT_SHIFT +: PCT_W];
            item_reg.light_status        <= status;
            item_reg.active_dark_level   <= dark_next;
            item_reg.active_bright_level <= bright_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[sv/light_level_smoother_classifier.sv]
// Top level of the light level smoother and classifier.
// Depends on lls_pkg, lls_stream_if, lls_window, lls_level_scale, lls_classify.
`default_nettype none

// Boxcar average over the last WINDOW_LEN light samples, scaled to percent
// and classified as dark, bright or normal against two active thresholds.
// One sample transfer is taken every clock cycle while no stage is stalled;
// the window update is registered at the transfer edge itself, then the
// division by the window length in the average stage and classification in
// the result register. That rate is set by the running-total update, which
// must finish before the next sample arrives. Each stage stalls only when
// the one below is full and held, so up to two more samples enter behind a
// waiting result before the sample side stalls. The sample ring starts all
// zero through per-entry fill bits: there is no clearing pass after reset.
// Mode 1 and mode 2 move the dark or bright threshold from the new average;
// the status of that item already uses the moved threshold. Threshold writes
// are always ready, take effect at once and are meant for idle periods; an
// unknown register index is dropped.

module light_level_smoother_classifier
    import lls_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lls_stream_if.sink   samples,
    lls_stream_if.source results,
    lls_stream_if.sink   cfg
);

    // Pointer and total widths follow from the window length
    localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOTAL_W = LEVEL_W + $clog2(WINDOW_LEN);

    logic               win_ready;
    logic               scale_ready;
    logic               cls_ready;
    logic               accept;
    stage_ctl_t         win_ctl;
    stage_ctl_t         scale_ctl;
    logic [TOTAL_W-1:0] total;
    level_t             level;
    thr_wr_t            thr_wr;
    in_item_t           in_item;
    out_item_t          out_item;
    cfg_item_t          cfg_item;

    // Sample transfer: accept whenever the window stage can move
    assign in_item       = samples.payload;
    assign samples.ready = win_ready;
    assign accept        = samples.valid && win_ready;

    // Decode threshold writes; drop unknown indexes
    assign cfg_item         = cfg.payload;
    assign cfg.ready        = 1'b1;
    assign thr_wr.dark_we   = cfg.valid && (cfg_item.index == REG_DARK_THRESHOLD);
    assign thr_wr.bright_we = cfg.valid && (cfg_item.index == REG_BRIGHT_THRESHOLD);
    assign thr_wr.data      = cfg_item.data;

    lls_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .PTR_W      (PTR_W),
        .TOTAL_W    (TOTAL_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (in_item),
        .ready_dn (scale_ready),
        .ready_up (win_ready),
        .ctl      (win_ctl),
        .total    (total)
    );

    lls_level_scale #(
        .WINDOW_LEN (WINDOW_LEN),
        .TOTAL_W    (TOTAL_W)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (win_ctl),
        .total    (total),
        .ready_dn (cls_ready),
        .ready_up (scale_ready),
        .ctl_out  (scale_ctl),
        .level    (level)
    );

    lls_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (scale_ctl),
        .level     (level),
        .thr_wr    (thr_wr),
        .out_ready (results.ready),
        .ready_up  (cls_ready),
        .out_valid (results.valid),
        .out_item  (out_item)
    );

    assign results.payload = out_item;

endmodule

`default_nettype wire

[sv/lls_checker.sv]
// Port-level checks for the light level smoother and classifier, bound to the top.
// Depends on lls_pkg and light_level_smoother_classifier_assert.svh.
`default_nettype none

`include "light_level_smoother_classifier_assert.svh"

module lls_checker
    import lls_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire level_t  level,
    input wire status_t status,
    input wire level_t  dark,
    input wire level_t  bright
);

    `LLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `LLS_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "sample side stalled with empty output")
    `LLS_ASSERT_SAME(a_dark_status, out_valid, (status == STATUS_DARK) == (level < dark), "dark status wrong")
    `LLS_ASSERT_SAME(a_bright_status, out_valid && (level >= dark), (status == STATUS_BRIGHT) == (level > bright), "bright status wrong")

endmodule

bind light_level_smoother_classifier lls_checker u_lls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .level     (results.payload.smoothed_level),
    .status    (results.payload.light_status),
    .dark      (results.payload.active_dark_level),
    .bright    (results.payload.active_bright_level)
);

`default_nettype wire

[verif/light_level_smoother_classifier_test.sv]
// Self-checking testbench for light_level_smoother_classifier.
// Uses lls_pkg and lls_stream_if. The expected results come from a local boxcar
// average and threshold predictor, and these are checked against the block's outputs.
`timescale 1ns / 100ps

module light_level_smoother_classifier_test
    import lls_pkg::*;
();

    localparam int WINDOW_LEN         = 8;
    localparam int RESET_CYCLES       = 6;
    localparam int STALL_LIMIT        = 2000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int PHASE_COUNT        = 8;
    localparam int ITEMS_PER_PHASE    = 235;
    localparam int PERCENT_FULL       = 100;
    localparam mode_t    MODE_UNUSED  = 2'd3;
    localparam cfg_idx_t CFG_IDX_TOP  = 4'd15;

    // Track the window, the running total and the live thresholds. Queue
    // one expected result for each accepted sample transfer.
    class level_scoreboard;
        level_t      ring[WINDOW_LEN];
        int unsigned total;
        int unsigned slot;
        level_t      dark_now;
        level_t      bright_now;
        out_item_t   expected_q[$];
        int unsigned errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            total      = 0;
            slot       = 0;
            dark_now   = DARK_RESET;
            bright_now = BRIGHT_RESET;
            errors     = 0;
        endfunction

        function void write_threshold(cfg_idx_t idx, level_t val);
            case (idx)
                REG_DARK_THRESHOLD:   dark_now = val;
                REG_BRIGHT_THRESHOLD: bright_now = val;
                default: ;
            endcase
        endfunction

        function void note_sample(in_item_t it);
            int unsigned level;
            int unsigned raised;
            out_item_t   want;
            total      = total - ring[slot] + it.sample;
            ring[slot] = it.sample;
            slot       = (slot + 1) % WINDOW_LEN;
            level      = total / WINDOW_LEN;
            case (it.mode)
                MODE_CAL_DARK:
                begin
                    raised   = level + CAL_MARGIN;
                    dark_now = (raised > LEVEL_MAX) ? LEVEL_MAX : level_t'(raised);
                end
                MODE_CAL_BRIGHT:
                begin
                    bright_now = (level < CAL_MARGIN) ? '0 : level_t'(level - CAL_MARGIN);
                end
                default: ;
            endcase
            want.smoothed_level     = level_t'(level);
            want.brightness_percent = pct_t'((level * PERCENT_FULL) / LEVEL_MAX);
            if (level < dark_now)
                want.light_status = STATUS_DARK;
            else if (level > bright_now)
                want.light_status = STATUS_BRIGHT;
            else
                want.light_status = STATUS_NORMAL;
            want.active_dark_level   = dark_now;
            want.active_bright_level = bright_now;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("smoothed_level", want.smoothed_level, got.smoothed_level);
            compare_field("brightness_percent", want.brightness_percent,
                          got.brightness_percent);
            compare_field("light_status", want.light_status, got.light_status);
            compare_field("active_dark_level", want.active_dark_level,
                          got.active_dark_level);
            compare_field("active_bright_level", want.active_bright_level,
                          got.active_bright_level);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;           // set for the last phase: no gaps on either side

    lls_stream_if #(.T(in_item_t))  sample_ch ();
    lls_stream_if #(.T(out_item_t)) result_ch ();
    lls_stream_if #(.T(cfg_item_t)) cfg_ch ();

    level_scoreboard sb;

    light_level_smoother_classifier #(
        .WINDOW_LEN (WINDOW_LEN)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one sample and hold it until the block takes it. Valid stays
    // high on return so back-to-back transfers need no extra edge; the caller
    // drops it when a gap or the end of a phase comes.
    task automatic push_sample(input mode_t mode, input level_t smp);
        in_item_t it;
        it.mode   = mode;
        it.sample = smp;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= it;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        sb.note_sample(it);
    endtask

    // Write one register; valid is left high for the caller to drop.
    task automatic write_reg(input cfg_idx_t idx, input level_t val);
        cfg_item_t w;
        w.index = idx;
        w.data  = val;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.write_threshold(idx, val);
    endtask

    // Drop the sample valid and wait out every outstanding result, then a
    // settling wait so the pipeline is surely empty.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random item: mostly samples around a wandering anchor so the average
    // sweeps across the thresholds, with some wild values and rail values.
    task automatic push_random(inout int anchor);
        int     pick;
        int     s;
        mode_t  mode;
        if ($urandom_range(0, 15) == 0)
            anchor = $urandom_range(0, 1023);
        pick = $urandom_range(0, 15);
        if (pick == 0)
            s = $urandom_range(0, 1023);
        else if (pick == 1)
            s = $urandom_range(0, 1) ? LEVEL_MAX : 0;
        else
        begin
            s = anchor + int'($urandom_range(0, 120)) - 60;
            if (s < 0) s = 0;
            if (s > LEVEL_MAX) s = LEVEL_MAX;
        end
        pick = $urandom_range(0, 15);
        if (pick <= 10)
            mode = MODE_PLAIN;
        else if (pick <= 12)
            mode = MODE_CAL_DARK;
        else if (pick <= 14)
            mode = MODE_CAL_BRIGHT;
        else
            mode = MODE_UNUSED;
        push_sample(mode, level_t'(s));
    endtask

    // Result side: hold ready high for a while, then stall in bursts of
    // random length. No stalls during the calm phase.
    initial
    begin
        result_ch.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (calm || $urandom_range(0, 7) != 0)
                result_ch.ready <= 1'b1;
            else
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.payload);
    end

    // End the run if no transfer happens on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int     anchor;
        level_t dark_val;
        level_t bright_val;
        sb   = new();
        calm = 1'b0;
        anchor = 512;
        rst_n             <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.payload    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset thresholds. Start from the zeroed
        // window so early averages count the empty entries.
        push_sample(MODE_PLAIN, '0);
        repeat (WINDOW_LEN) push_sample(MODE_PLAIN, LEVEL_MAX);
        // Full-scale level: dark calibration must cap at the top rail.
        push_sample(MODE_CAL_DARK, LEVEL_MAX);
        // Unused mode behaves as a plain sample.
        push_sample(MODE_UNUSED, 10'd512);
        // Pull the average to zero while calibrating bright; the last steps
        // fall below the margin and must floor at zero.
        repeat (WINDOW_LEN) push_sample(MODE_CAL_BRIGHT, '0);
        // Dark calibration at level zero; status judged on the new threshold.
        push_sample(MODE_CAL_DARK, '0);
        push_sample(MODE_UNUSED, LEVEL_MAX);
        drain();

        // Random phases, each with its own threshold setting. The first
        // four cover the corners, the rest are random. Writes happen only
        // with the pipeline empty.
        for (int phase = 1; phase <= PHASE_COUNT; phase++)
        begin
            case (phase)
                1:
                begin
                    dark_val   = '0;
                    bright_val = LEVEL_MAX;
                end
                2:
                begin
                    dark_val   = LEVEL_MAX;
                    bright_val = '0;
                end
                3:
                begin
                    dark_val   = '0;
                    bright_val = '0;
                end
                4:
                begin
                    dark_val   = LEVEL_MAX;
                    bright_val = LEVEL_MAX;
                end
                default:
                begin
                    dark_val   = level_t'($urandom_range(0, 1023));
                    bright_val = level_t'($urandom_range(0, 1023));
                end
            endcase
            // Unmapped indexes must be dropped without touching anything.
            if (phase == 1)
                write_reg(CFG_IDX_TOP, LEVEL_MAX);
            else if ($urandom_range(0, 1) == 0)
                write_reg(cfg_idx_t'($urandom_range(REG_BRIGHT_THRESHOLD + 1, CFG_IDX_TOP)),
                          level_t'($urandom_range(0, 1023)));
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_DARK_THRESHOLD, dark_val);
                write_reg(REG_BRIGHT_THRESHOLD, bright_val);
            end
            else
            begin
                write_reg(REG_BRIGHT_THRESHOLD, bright_val);
                write_reg(REG_DARK_THRESHOLD, dark_val);
            end
            cfg_ch.valid <= 1'b0;
            @(posedge clk);

            calm = (phase == PHASE_COUNT);
            repeat (ITEMS_PER_PHASE) push_random(anchor);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
